// File: rtl/core/wgmp_pkg.sv
// Shared types and constants for the wrap-around grid min-path block.
package wgmp_pkg;

  typedef enum logic [1:0] {
    PH_LOAD,
    PH_SOLVE,
    PH_PICK,
    PH_EMIT
  } phase_t;

  localparam int unsigned CfgIdxW     = 1;
  localparam logic [CfgIdxW-1:0] CFG_ROW_COUNT    = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_COLUMN_COUNT = 1'b1;
  localparam int unsigned CfgDataW    = 7;
  localparam int unsigned RowFieldW   = 5;
  localparam int unsigned ColFieldW   = 7;
  localparam int unsigned CostOutW    = 37;

  // Per-cycle control from the solve sequencer to every cell.
  typedef struct packed {
    logic       advance;    // cells take a new column this cycle
    logic       seed;       // first column: cost is the weight alone
  } cell_ctl_t;

endpackage

// File: rtl/core/wgmp_cell.sv
// One row cell: holds the running path cost of its row.
module wgmp_cell #(
  parameter int unsigned COST_W = 38,
  parameter int unsigned ROW_W  = 4
) (
  input  logic                     clk,
  input  wgmp_pkg::cell_ctl_t      ctl,
  input  logic signed [COST_W-1:0] w,        // this row's weight, column in work
  input  logic signed [COST_W-1:0] c_lo,     // smallest-index neighbor cost
  input  logic signed [COST_W-1:0] c_mid,
  input  logic signed [COST_W-1:0] c_hi,
  input  logic [ROW_W-1:0]         r_lo,
  input  logic [ROW_W-1:0]         r_mid,
  input  logic [ROW_W-1:0]         r_hi,
  output logic signed [COST_W-1:0] cost,
  output logic [ROW_W-1:0]         succ
);
  logic signed [COST_W-1:0] low;
  logic [ROW_W-1:0]         pick;

  always_comb begin
    low  = c_lo;
    pick = r_lo;
    if (c_mid < low) begin
      low  = c_mid;
      pick = r_mid;
    end
    if (c_hi < low) begin
      low  = c_hi;
      pick = r_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      cost <= ctl.seed ? w : low + w;
      succ <= pick;
    end
  end
endmodule

// File: rtl/core/wraparound_grid_min_path.sv
// Top level of the wrap-around grid least-sum path finder.
// The grid arrives one weight per transfer, row-major, into a weight memory
// with one write port. After the last weight the block solves one column per
// cycle from the last column back to the first, in a row of MAX_ROWS cells,
// one per grid row, each keeping its row's path cost and taking the three
// wrapped neighbor costs from the adjacent cells. Per column one memory row
// (all rows of one column) is read into a register ahead of the cells; then a
// scan over the R rows finds the best start row, then C results are sent,
// each as a successor read, then the transfer, plus any output stall. No
// weight is accepted during solve, scan and emission.
module wraparound_grid_min_path #(
  parameter int unsigned MAX_ROWS    = 16,
  parameter int unsigned MAX_COLS    = 64,
  parameter int unsigned WEIGHT_BITS = 31
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [((WEIGHT_BITS+7)/8)*8-1:0] s_axis_tdata,  // [WEIGHT_BITS-1:0] weight
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [4:0] path_row, [41:5] total_cost
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [wgmp_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [wgmp_pkg::CfgDataW-1:0] cfg_data
);
  localparam int unsigned RowW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned ColW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned CostW = WEIGHT_BITS + 7;
  localparam int unsigned CostOutW_l = wgmp_pkg::CostOutW;

  typedef logic signed [CostW-1:0] cost_t;

  // configuration, clamped
  logic [4:0] row_count;
  logic [6:0] column_count;
  logic [RowW:0] rows;
  logic [ColW:0] cols;
  always_comb begin
    if (row_count == '0) rows = (RowW+1)'(1);
    else if (32'(row_count) > MAX_ROWS) rows = (RowW+1)'(MAX_ROWS);
    else rows = (RowW+1)'(row_count);
    if (column_count == '0) cols = (ColW+1)'(1);
    else if (32'(column_count) > MAX_COLS) cols = (ColW+1)'(MAX_COLS);
    else cols = (ColW+1)'(column_count);
  end

  wgmp_pkg::phase_t phase, phase_next;
  logic [RowW-1:0] ld_row;
  logic [ColW-1:0] ld_col;
  logic [ColW-1:0] sv_col;     // next column to read
  logic            sv_iss;     // column reads still to issue
  logic            sv_rd;      // wrow holds column sv_ccol
  logic [ColW-1:0] sv_ccol;    // column in the cells this cycle
  logic            sv_first;
  logic [RowW-1:0] pk_row, best_row;
  cost_t           best_cost;
  logic [ColW-1:0] em_col;
  logic [RowW-1:0] em_row;
  logic [ColW-1:0] succ_col;   // column whose successors sit in the cells
  logic            succ_v;

  // weight memory: one word per column holds all rows
  logic [MAX_ROWS*WEIGHT_BITS-1:0] wmem [MAX_COLS];
  logic [MAX_ROWS*WEIGHT_BITS-1:0] wrow;
  // successor memory, one word per column
  logic [MAX_ROWS*RowW-1:0] smem [MAX_COLS];
  logic [MAX_ROWS*RowW-1:0] srow;
  logic [MAX_ROWS*RowW-1:0] scur;

  logic in_acc, out_acc, last_load, solve_en, solve_done, pick_done;
  assign s_axis_tready = (phase == wgmp_pkg::PH_LOAD);
  assign in_acc  = s_axis_tvalid & s_axis_tready;
  assign out_acc = m_axis_tvalid & m_axis_tready;
  assign last_load = ({1'b0, ld_row} == rows - 1'b1) && ({1'b0, ld_col} == cols - 1'b1);

  // weight memory write: one row slice of a column word per transfer
  always_ff @(posedge clk) begin
    if (in_acc)
      wmem[ld_col][ld_row*WEIGHT_BITS +: WEIGHT_BITS] <= s_axis_tdata[WEIGHT_BITS-1:0];
    wrow <= wmem[sv_col];
  end

  // cell row
  cost_t cost [MAX_ROWS];
  logic [RowW-1:0] succ [MAX_ROWS];
  wgmp_pkg::cell_ctl_t ctl;
  assign ctl.advance = solve_en;
  assign ctl.seed    = sv_first;

  for (genvar r = 0; r < MAX_ROWS; r++) begin : g_cell
    logic [RowW-1:0] up, dn, a, b, c, t;
    cost_t w;
    always_comb begin
      up = (r == 0) ? RowW'(rows - 1'b1) : RowW'(r - 1);
      dn = ((r + 1) == 32'(rows)) ? '0 : RowW'(r + 1);
      // sort three rows ascending
      a = up; b = RowW'(r); c = dn;
      t = '0;
      if (a > b) begin t = a; a = b; b = t; end
      if (b > c) begin t = b; b = c; c = t; end
      if (a > b) begin t = a; a = b; b = t; end
    end
    assign w = CostW'($signed(wrow[r*WEIGHT_BITS +: WEIGHT_BITS]));
    wgmp_cell #(.COST_W(CostW), .ROW_W(RowW)) u_cell (
      .clk(clk), .ctl(ctl), .w(w),
      .c_lo(cost[a]), .c_mid(cost[b]), .c_hi(cost[c]),
      .r_lo(a), .r_mid(b), .r_hi(c),
      .cost(cost[r]), .succ(succ[r])
    );
    assign srow[r*RowW +: RowW] = succ[r];
  end

  // successor write, in the cycle after the cells took the column
  always_ff @(posedge clk) begin
    if (succ_v) smem[succ_col] <= srow;
    scur <= smem[em_col];
  end

  // start-row scan: row 0 seeds the running best, strict compare keeps ties low
  logic pk_better;
  assign pk_better = (pk_row == '0) || (cost[pk_row] < best_cost);

  assign solve_en   = (phase == wgmp_pkg::PH_SOLVE) && sv_rd;
  assign solve_done = solve_en && (sv_ccol == '0);
  assign pick_done  = (phase == wgmp_pkg::PH_PICK) && ({1'b0, pk_row} == rows - 1'b1);

  always_comb begin
    phase_next = phase;
    case (phase)
      wgmp_pkg::PH_LOAD:  if (in_acc && last_load && !cfg_we) phase_next = wgmp_pkg::PH_SOLVE;
      wgmp_pkg::PH_SOLVE: if (solve_done) phase_next = wgmp_pkg::PH_PICK;
      wgmp_pkg::PH_PICK:  if (pick_done) phase_next = wgmp_pkg::PH_EMIT;
      wgmp_pkg::PH_EMIT:
        if (out_acc && {1'b0, em_col} == cols - 1'b1) phase_next = wgmp_pkg::PH_LOAD;
      default: phase_next = wgmp_pkg::PH_LOAD;
    endcase
  end

  // emission holds a registered successor read; out_v marks data ready
  logic out_v;
  assign m_axis_tvalid = (phase == wgmp_pkg::PH_EMIT) && out_v;
  assign m_axis_tlast  = ({1'b0, em_col} == cols - 1'b1);
  logic [CostOutW_l-1:0] cost_out;
  assign cost_out = m_axis_tlast ? best_cost[CostOutW_l-1:0] : '0;
  assign m_axis_tdata = {6'b0, cost_out, wgmp_pkg::RowFieldW'(em_row) + 5'd1};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= wgmp_pkg::PH_LOAD;
      row_count    <= 5'd10;
      column_count <= 7'd64;
      ld_row <= '0;
      ld_col <= '0;
      sv_iss <= 1'b0;
      sv_rd  <= 1'b0;
      succ_v <= 1'b0;
      out_v  <= 1'b0;
    end else begin
      phase <= phase_next;
      if (cfg_we) begin
        if (cfg_index == wgmp_pkg::CFG_ROW_COUNT) row_count <= cfg_data[4:0];
        else if (cfg_index == wgmp_pkg::CFG_COLUMN_COUNT) column_count <= cfg_data;
        ld_row <= '0;
        ld_col <= '0;
      end else if (in_acc) begin
        if (last_load) begin
          ld_row <= '0;
          ld_col <= '0;
        end else if ({1'b0, ld_col} == cols - 1'b1) begin
          ld_col <= '0;
          ld_row <= ld_row + 1'b1;
        end else
          ld_col <= ld_col + 1'b1;
      end
      // solve sequencer: read column, then cells take it the next cycle
      if (phase == wgmp_pkg::PH_LOAD) begin
        sv_col   <= ColW'(cols - 1'b1);
        sv_iss   <= 1'b1;
        sv_rd    <= 1'b0;
        sv_first <= 1'b1;
      end else if (phase == wgmp_pkg::PH_SOLVE) begin
        sv_rd   <= sv_iss;
        sv_ccol <= sv_col;
        if (sv_iss) begin
          if (sv_col == '0) sv_iss <= 1'b0;
          else sv_col <= sv_col - 1'b1;
        end
        if (sv_rd) sv_first <= 1'b0;
      end
      succ_v   <= solve_en && !sv_first;
      succ_col <= sv_ccol;
      // start-row scan
      if (phase == wgmp_pkg::PH_SOLVE) begin
        pk_row <= '0;
      end else if (phase == wgmp_pkg::PH_PICK) begin
        if ({1'b0, pk_row} != rows - 1'b1) pk_row <= pk_row + 1'b1;
        if (pk_better) begin
          best_cost <= cost[pk_row];
          best_row  <= pk_row;
        end
      end
      // emission
      if (phase == wgmp_pkg::PH_PICK) begin
        em_col <= '0;
        em_row <= pk_better ? pk_row : best_row;
        out_v  <= 1'b0;
      end else if (phase == wgmp_pkg::PH_EMIT) begin
        if (!out_v) out_v <= 1'b1;
        else if (out_acc) begin
          em_col <= em_col + 1'b1;
          em_row <= scur[em_row*RowW +: RowW];
          out_v  <= 1'b0;
        end
      end else
        out_v <= 1'b0;
    end
  end
endmodule

// File: bench/grid_path_checker.sv
// Checker for the wrap-around grid least-sum path block: predicts and compares results.
module grid_path_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [wgmp_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [wgmp_pkg::CfgDataW-1:0] cfg_data,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_ROWS = 16;
  localparam int GRID_COLS = 64;

  typedef struct packed {
    logic [4:0]  path_row;
    logic [36:0] total_cost;
    logic        last;
  } path_step_t;

  path_step_t  path_q[$];
  longint      grid[GRID_ROWS][GRID_COLS];
  int          next_row[GRID_ROWS][GRID_COLS];
  logic [4:0]  rows_reg;
  logic [6:0]  cols_reg;
  int          fill_pos;

  function automatic int rows_used();
    if (rows_reg == 0) return 1;
    if (rows_reg > GRID_ROWS) return GRID_ROWS;
    return int'(rows_reg);
  endfunction

  function automatic int cols_used();
    if (cols_reg == 0) return 1;
    if (cols_reg > GRID_COLS) return GRID_COLS;
    return int'(cols_reg);
  endfunction

  // Backward DP over columns, then walk the successor table from the best start.
  function automatic void solve_grid(int rows, int cols);
    longint     acc[GRID_ROWS];
    longint     nxt[GRID_ROWS];
    longint     low;
    int         cand[3];
    int         t, pick, start, row;
    path_step_t s;
    for (int r = 0; r < rows; r++) acc[r] = grid[r][cols-1];
    for (int col = cols - 1; col > 0; col--) begin
      for (int r = 0; r < rows; r++) begin
        cand[0] = (r == 0) ? rows - 1 : r - 1;
        cand[1] = r;
        cand[2] = (r + 1 == rows) ? 0 : r + 1;
        // ascending row order so strict compare keeps the lowest row on ties
        if (cand[0] > cand[1]) begin t = cand[0]; cand[0] = cand[1]; cand[1] = t; end
        if (cand[1] > cand[2]) begin t = cand[1]; cand[1] = cand[2]; cand[2] = t; end
        if (cand[0] > cand[1]) begin t = cand[0]; cand[0] = cand[1]; cand[1] = t; end
        pick = cand[0];
        low  = acc[cand[0]];
        for (int k = 1; k < 3; k++) begin
          if (acc[cand[k]] < low) begin
            low  = acc[cand[k]];
            pick = cand[k];
          end
        end
        next_row[r][col-1] = pick;
        nxt[r] = low + grid[r][col-1];
      end
      for (int r = 0; r < rows; r++) acc[r] = nxt[r];
    end
    start = 0;
    low   = acc[0];
    for (int r = 1; r < rows; r++) begin
      if (acc[r] < low) begin
        low   = acc[r];
        start = r;
      end
    end
    row = start;
    for (int c = 0; c < cols; c++) begin
      s.path_row   = 5'(row + 1);
      s.last       = (c + 1 == cols);
      s.total_cost = s.last ? low[36:0] : '0;
      path_q.push_back(s);
      if (!s.last) row = next_row[row][c];
    end
  endfunction

  always @(posedge clk) begin
    int         rows, cols, pos;
    path_step_t want;
    if (rst) begin
      rows_reg = 5'd10;
      cols_reg = 7'd64;
      fill_pos = 0;
      errors   = 0;
      path_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (path_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result transfer: tdata=%h last=%b",
                                     m_axis_tdata, m_axis_tlast);
        end else begin
          want = path_q.pop_front();
          if (m_axis_tdata[4:0] !== want.path_row || m_axis_tdata[41:5] !== want.total_cost ||
              m_axis_tlast !== want.last) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp row=%0d cost=%h last=%b, got row=%0d cost=%h last=%b",
                       want.path_row, want.total_cost, want.last,
                       m_axis_tdata[4:0], m_axis_tdata[41:5], m_axis_tlast);
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == wgmp_pkg::CFG_ROW_COUNT) begin
          rows_reg = cfg_data[4:0];
          fill_pos = 0;
        end else if (cfg_index == wgmp_pkg::CFG_COLUMN_COUNT) begin
          cols_reg = cfg_data[6:0];
          fill_pos = 0;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        rows = rows_used();
        cols = cols_used();
        pos  = (fill_pos >= rows * cols) ? 0 : fill_pos;
        grid[pos / cols][pos % cols] = longint'($signed(s_axis_tdata[30:0]));
        if (pos + 1 < rows * cols) begin
          fill_pos = pos + 1;
        end else begin
          fill_pos = 0;
          solve_grid(rows, cols);
        end
      end
    end
    pending = path_q.size();
  end

endmodule

// File: bench/tb_top.sv
// Top of the bench: clock, reset, stimulus and verdict for the grid path block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;  // idle cycles
  localparam int ITEM_TARGET    = 480;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [30:0] weight, [31] pad
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // [4:0] path_row, [41:5] total_cost
  logic        m_axis_tlast;
  logic        cfg_we = 1'b0;
  logic [wgmp_pkg::CfgIdxW-1:0]  cfg_index = wgmp_pkg::CFG_ROW_COUNT;
  logic [wgmp_pkg::CfgDataW-1:0] cfg_data = '0;

  int  errors;
  int  pending;
  int  weights_sent;
  int  quiet_cycles;
  bit  no_gaps;      // when set, both sides run back to back

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  wraparound_grid_min_path dut (.*);

  grid_path_checker checker_i (.*);

  // Watchdog: counts cycles without any transfer on either stream.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: random stall before each transfer, raised once per result.
  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
      @(negedge clk);
    end
  end

  // One weight transfer; valid stays high into the next call unless it idles.
  task automatic send_weight(logic [31:0] word);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    @(negedge clk);
    weights_sent++;
  endtask

  // Registers change only once the block has drained and settled.
  task automatic write_reg(logic [wgmp_pkg::CfgIdxW-1:0] idx, int unsigned val);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= wgmp_pkg::CfgDataW'(val);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [31:0] pick_weight(int kind);
    logic [31:0] w;
    w = $urandom();
    case (kind)
      0: w[30:0] = 31'($signed($urandom_range(0, 4)) - 2);   // small: many ties
      1: w[30:0] = ($urandom_range(0, 1) != 0) ? 31'h3FFF_FFFF : 31'h4000_0000;
      default: ;                                             // full range
    endcase
    return w;
  endfunction

  initial begin
    int rows, cols, kind;
    bit big_done;
    weights_sent = 0;
    big_done     = 1'b0;
    no_gaps      = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: single-cell grids with weight extremes, pad bit set on some.
    write_reg(wgmp_pkg::CFG_ROW_COUNT, 1);
    write_reg(wgmp_pkg::CFG_COLUMN_COUNT, 1);
    send_weight(32'h3FFF_FFFF);
    send_weight(32'hC000_0000);
    send_weight(32'h0000_0000);
    send_weight(32'hFFFF_FFFF);
    // zero in both registers acts as one
    write_reg(wgmp_pkg::CFG_ROW_COUNT, 0);
    write_reg(wgmp_pkg::CFG_COLUMN_COUNT, 0);
    send_weight(32'h0000_1234);
    // rows above the maximum clamp to 16; all-equal column ties on row 1
    write_reg(wgmp_pkg::CFG_ROW_COUNT, 31);
    write_reg(wgmp_pkg::CFG_COLUMN_COUNT, 1);
    for (int i = 0; i < 16; i++) send_weight(32'h0000_0005);
    // partial load dropped by a register write
    write_reg(wgmp_pkg::CFG_ROW_COUNT, 2);
    write_reg(wgmp_pkg::CFG_COLUMN_COUNT, 127);
    for (int i = 0; i < 3; i++) send_weight($urandom());
    write_reg(wgmp_pkg::CFG_COLUMN_COUNT, 2);
    for (int i = 0; i < 4; i++) send_weight(pick_weight(i % 3));

    // Random grids, mostly small; one grid at the full column count partway through.
    while (weights_sent < ITEM_TARGET) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      kind    = $urandom_range(0, 3);
      if (!big_done && weights_sent > 150) begin
        big_done = 1'b1;
        rows = $urandom_range(1, 3);
        cols = ($urandom_range(0, 1) != 0) ? 64 : $urandom_range(65, 127);
      end else if ($urandom_range(0, 9) == 0) begin
        rows = $urandom_range(16, 31);
        cols = $urandom_range(0, 3);
      end else begin
        rows = $urandom_range(0, 6);
        cols = $urandom_range(0, 10);
      end
      write_reg(wgmp_pkg::CFG_ROW_COUNT, rows);
      write_reg(wgmp_pkg::CFG_COLUMN_COUNT, cols);
      rows = (rows == 0) ? 1 : (rows > 16) ? 16 : rows;
      cols = (cols == 0) ? 1 : (cols > 64) ? 64 : cols;
      for (int i = 0; i < rows * cols; i++)
        send_weight(pick_weight((kind == 3) ? $urandom_range(0, 2) : kind));
    end
    s_axis_tvalid <= 1'b0;
    no_gaps = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (errors == 0 && pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
